>>> rtl/pool_and_bump_arena_allocator_core_assert.svh
// Assertion macros for the arena allocator core.
// No dependencies; included by the top level inside its module body.
`ifndef POOL_AND_BUMP_ARENA_ALLOCATOR_CORE_ASSERT_SVH
`define POOL_AND_BUMP_ARENA_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pba_pkg.sv
// Shared types and constants for the pool and bump arena allocator.
// No dependencies.
package pba_pkg;

  localparam int ADDR_W      = 48;
  localparam int LEN_W       = 41;
  localparam int SHIFT_W     = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int MAX_POOLS_D = 4096;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd6;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd30;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd18;
  localparam int                 LINE_BYTES  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT      = 3'd4;

  typedef enum logic [1:0] {
    OP_ACQUIRE  = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_ALLOC    = 2'd2,
    OP_CONTAINS = 2'd3
  } pba_op_t;

  typedef struct packed {
    pba_op_t           operation;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  request_bytes;
  } pba_in_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] result_address;
    logic              first_exhaustion;
    logic              push_dropped;
  } pba_out_t;

  // Configuration as seen by the datapath, with derived zone bounds.
  typedef struct packed {
    logic               enabled;
    logic [ADDR_W-1:0]  arena_base;
    logic [LEN_W-1:0]   large_bytes;
    logic [ADDR_W:0]    pool_start;
    logic [LEN_W-1:0]   pool_span;
    logic [ADDR_W:0]    arena_end;
    logic [SHIFT_W-1:0] shift;
  } pba_cfg_t;

endpackage

>>> rtl/pba_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/pba_cfg.sv
// Configuration registers and derived zone bounds.
// Depends on pba_pkg.
module pba_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pba_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [pba_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output pba_pkg::pba_cfg_t                  cfg
);
  import pba_pkg::*;

  logic               enabled_r;
  logic [ADDR_W-1:0]  base_r;
  logic [LEN_W-1:0]   total_r;
  logic [LEN_W-1:0]   large_r;
  logic [SHIFT_W-1:0] shift_r;
  pba_cfg_t           cfg_r;
  pba_cfg_t           cfg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      base_r    <= '0;
      total_r   <= '0;
      large_r   <= '0;
      shift_r   <= SHIFT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ENABLED:    enabled_r <= cfg_wdata[0];
        CFG_ARENA_BASE: base_r    <= cfg_wdata[ADDR_W-1:0];
        CFG_TOTAL:      total_r   <= cfg_wdata[LEN_W-1:0];
        CFG_LARGE:      large_r   <= cfg_wdata[LEN_W-1:0];
        CFG_SHIFT:      shift_r   <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_nxt.enabled     = enabled_r;
    cfg_nxt.arena_base  = base_r;
    cfg_nxt.large_bytes = large_r;
    cfg_nxt.pool_start  = {1'b0, base_r} + (ADDR_W+1)'(large_r);
    cfg_nxt.arena_end   = {1'b0, base_r} + (ADDR_W+1)'(total_r);
    // pool zone is empty when the large zone overruns the arena
    cfg_nxt.pool_span   = (total_r >= large_r) ? (total_r - large_r) : '0;
    if (shift_r < SHIFT_MIN) begin
      cfg_nxt.shift = SHIFT_MIN;
    end else if (shift_r > SHIFT_MAX) begin
      cfg_nxt.shift = SHIFT_MAX;
    end else begin
      cfg_nxt.shift = shift_r;
    end
  end

  // bounds registered; user must write only while idle (unenforced)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{enabled: 1'b0, arena_base: '0, large_bytes: '0, pool_start: '0,
                 pool_span: '0, arena_end: '0, shift: SHIFT_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/pba_exec.sv
// Allocator state and the single-pass operation datapath with the free stack.
// Depends on pba_pkg and pba_ram.
module pba_exec #(
  parameter int MAX_POOLS = pba_pkg::MAX_POOLS_D
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  pba_pkg::pba_in_t  item,
  input  pba_pkg::pba_cfg_t cfg,
  output pba_pkg::pba_out_t result
);
  import pba_pkg::*;

  localparam int IW  = $clog2(MAX_POOLS);
  localparam int CW  = $clog2(MAX_POOLS + 1);
  localparam int SHA = CW + 31;
  localparam int SHW = (SHA > LEN_W + 1) ? SHA : LEN_W + 1;

  logic [LEN_W-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0]    pools_r, pools_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             pool_warned_r, pool_warned_nxt;
  logic             large_warned_r, large_warned_nxt;
  logic             byp_hit_r;
  logic [IW-1:0]    byp_data_r;

  logic             we;
  logic [IW-1:0]    waddr, raddr, wdata, rdata, top_idx;
  logic [CW-1:0]    count_eff;
  logic [SHW-1:0]   fresh_end;
  logic [ADDR_W:0]  rel_addr, rel_off, rel_idx;
  logic [LEN_W:0]   aligned, bump_end;

  // the RAM write must only happen on a processed beat
  pba_ram #(.WIDTH(IW), .DEPTH(MAX_POOLS)) u_stack (
    .clk   (clk),
    .we    (we && fire),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign top_idx   = byp_hit_r ? byp_data_r : rdata;
  assign fresh_end = (SHW'(pools_r) + SHW'(1)) << cfg.shift;
  assign rel_addr  = {1'b0, item.address};
  assign rel_off   = rel_addr - cfg.pool_start;
  assign rel_idx   = rel_off >> cfg.shift;
  assign aligned   = ({1'b0, item.request_bytes} + (LEN_W+1)'(LINE_BYTES - 1))
                     & ~(LEN_W+1)'(LINE_BYTES - 1);
  assign bump_end  = {1'b0, cursor_r} + aligned;

  always_comb begin
    cursor_nxt       = cursor_r;
    pools_nxt        = pools_r;
    count_nxt        = count_r;
    pool_warned_nxt  = pool_warned_r;
    large_warned_nxt = large_warned_r;
    we               = 1'b0;
    waddr            = count_r[IW-1:0];
    wdata            = rel_idx[IW-1:0];
    result           = '0;
    case (item.operation)
      OP_ACQUIRE: begin
        if (cfg.enabled) begin
          if (count_r != '0) begin
            count_nxt             = count_r - CW'(1);
            result.ok             = 1'b1;
            result.result_address = cfg.pool_start[ADDR_W-1:0]
                                    + (ADDR_W'(top_idx) << cfg.shift);
          end else if (pools_r < CW'(MAX_POOLS) && fresh_end <= SHW'(cfg.pool_span)) begin
            pools_nxt             = pools_r + CW'(1);
            result.ok             = 1'b1;
            result.result_address = cfg.pool_start[ADDR_W-1:0]
                                    + (ADDR_W'(pools_r) << cfg.shift);
          end else begin
            result.first_exhaustion = !pool_warned_r;
            pool_warned_nxt         = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        if (item.address != '0 && rel_addr >= cfg.pool_start
            && rel_off < (ADDR_W+1)'(cfg.pool_span)
            && rel_idx < (ADDR_W+1)'(MAX_POOLS)) begin
          if (count_r >= CW'(MAX_POOLS)) begin
            result.push_dropped = 1'b1;
          end else begin
            we        = 1'b1;
            count_nxt = count_r + CW'(1);
            result.ok = 1'b1;
          end
        end
      end
      OP_ALLOC: begin
        if (cfg.enabled && item.request_bytes != '0) begin
          if (aligned <= {1'b0, cfg.large_bytes} && bump_end <= {1'b0, cfg.large_bytes}) begin
            cursor_nxt            = bump_end[LEN_W-1:0];
            result.ok             = 1'b1;
            result.result_address = cfg.arena_base + ADDR_W'(cursor_r);
          end else begin
            result.first_exhaustion = !large_warned_r;
            large_warned_nxt        = 1'b1;
          end
        end
      end
      OP_CONTAINS: begin
        result.ok = cfg.enabled && item.address >= cfg.arena_base
                    && rel_addr < cfg.arena_end;
      end
      default: ;
    endcase
  end

  // Read the top entry of the stack as it will stand after this beat; a push to
  // that same slot is forwarded around the RAM.
  assign count_eff = fire ? count_nxt : count_r;
  assign raddr     = IW'(count_eff - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r       <= '0;
      pools_r        <= '0;
      count_r        <= '0;
      pool_warned_r  <= 1'b0;
      large_warned_r <= 1'b0;
      byp_hit_r      <= 1'b0;
    end else begin
      byp_hit_r <= fire && we && (waddr == raddr);
      if (fire) begin
        cursor_r       <= cursor_nxt;
        pools_r        <= pools_nxt;
        count_r        <= count_nxt;
        pool_warned_r  <= pool_warned_nxt;
        large_warned_r <= large_warned_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= wdata;
  end

endmodule

>>> rtl/pool_and_bump_arena_allocator_core.sv
// Top level of the pool and bump arena allocator.
// Depends on pba_pkg, pba_cfg, pba_exec (which holds pba_ram) and the assert header.
//
// Usage:
//   Requests enter on in_valid/in_ready/in_data, one beat per operation
//   (acquire pool, release pool, large alloc, contains). Each request gives
//   exactly one result beat on out_valid/out_ready/out_data, in order.
//   Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata), written
//   only while no request is in flight; a beat accepted after the write sees it.
// Timing:
//   A beat accepted is held in the input register, processed once the result
//   register is free or being emptied, and lands in the result register,
//   which drives out_valid. Throughput is one beat per cycle while out_ready
//   is high; the free-stack top is prefetched from the stack RAM's registered
//   read port with a forward path for a push to the same slot, so pop after
//   push runs back to back.
// Reset (rst_n low, synchronous): counters, cursor, warning flags and the
//   handshake registers clear; configuration returns to its defaults. The
//   stack RAM needs no clearing, since only slots below the count are read.
//   in_ready is low while reset is held.
// Stall: with out_ready low the result holds; the input register takes one
//   more beat, then in_ready drops until the result is taken.
module pool_and_bump_arena_allocator_core #(
  parameter int MAX_POOLS = pba_pkg::MAX_POOLS_D
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pba_pkg::pba_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pba_pkg::pba_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [pba_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [pba_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pba_pkg::*;
  `include "pool_and_bump_arena_allocator_core_assert.svh"

  pba_cfg_t cfg;
  pba_in_t  in_r;
  logic     in_valid_r;
  pba_out_t out_r;
  logic     out_valid_r;
  pba_out_t result;
  logic     fire;

  pba_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pba_exec #(.MAX_POOLS(MAX_POOLS)) u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_r),
    .cfg    (cfg),
    .result (result)
  );

  // process the held beat when the result register is free or being emptied
  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = rst_n && (!in_valid_r || fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PBA_ASSERT_NXT(a_accept_held, clk, rst_n, in_valid && in_ready, in_valid_r,
                  "accepted beat not held in input register")
  `PBA_ASSERT_IMP(a_free_ready, clk, rst_n, in_valid_r && !out_valid_r, in_ready,
                  "stalled with an empty result register")
  `PBA_ASSERT_IMP(a_fail_no_addr, clk, rst_n, out_valid && !out_data.ok,
                  out_data.result_address == '0, "failed result carries an address")
  `PBA_ASSERT_IMP(a_flags_excl, clk, rst_n, out_valid && out_data.first_exhaustion,
                  !out_data.ok && !out_data.push_dropped, "exhaustion flag on non-failure")

endmodule
